/* hw/rtl/ehr_pkg.sv */
// Shared types and constants for the ECG heart rate detector.
package ehr_pkg;

    localparam int HistDepth   = 5;
    localparam int RateCap     = 300;
    localparam int IndexMax    = 65535;
    localparam int MsPerMin    = 60000;

    localparam logic [2:0] RegBaseShift  = 3'd0;
    localparam logic [2:0] RegThrShift   = 3'd1;
    localparam logic [2:0] RegRefractory = 3'd2;
    localparam logic [2:0] RegMinIntv    = 3'd3;
    localparam logic [2:0] RegMaxIntv    = 3'd4;
    localparam logic [2:0] RegAlertBpm   = 3'd5;
    localparam logic [2:0] RegAlertFrm   = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILTER,
        ST_SMOOTH,
        ST_DETECT,
        ST_SUM,
        ST_DIVIDE,
        ST_FRAME,
        ST_OUTPUT
    } t_state;

    typedef struct packed {
        logic [3:0]  baseline_shift;
        logic [3:0]  threshold_shift;
        logic [10:0] refractory_ms;
        logic [11:0] min_interval_ms;
        logic [11:0] max_interval_ms;
        logic [8:0]  rate_alert_bpm;
        logic [2:0]  alert_frames;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic leads_off;
        logic filter;
        logic smooth;
        logic detect;
        logic sum_start;
        logic sum_step;
        logic div_start;
        logic div_step;
        logic frame;
    } t_cmd;

    typedef struct packed {
        logic need_rate;
        logic sum_done;
        logic div_done;
    } t_sts;

    typedef struct packed {
        logic        beat;
        logic [11:0] interval_ms;
        logic [8:0]  heart_rate;
        logic        rate_alert;
        logic        leads_off_alert;
    } t_result;

endpackage

/* hw/rtl/ehr_if.sv */
// Valid/ready channel interfaces for samples and results.
interface ehr_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [11:0] sample;
    logic        frame_start;
    logic        frame_end;
    modport source (output valid, kind, sample, frame_start, frame_end, input ready);
    modport sink (input valid, kind, sample, frame_start, frame_end, output ready);
endinterface

interface ehr_out_if;
    logic        valid;
    logic        ready;
    logic        beat;
    logic [11:0] interval_ms;
    logic [8:0]  heart_rate;
    logic        rate_alert;
    logic        leads_off_alert;
    modport source (output valid, beat, interval_ms, heart_rate, rate_alert, leads_off_alert,
                    input ready);
    modport sink (input valid, beat, interval_ms, heart_rate, rate_alert, leads_off_alert,
                  output ready);
endinterface

/* hw/rtl/ehr_datapath.sv */
// Datapath: filters, threshold, beat timing, interval ring, rate divider, alert run.
module ehr_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ehr_pkg::t_cfg     i_cfg,
    input  ehr_pkg::t_cmd     i_cmd,
    input  logic [11:0]       i_sample,
    input  logic              i_frame_start,
    input  logic              i_frame_end,
    output ehr_pkg::t_sts     o_sts,
    output ehr_pkg::t_result  o_result
);
    // Signed state; 25 bits holds every reachable filter and threshold value.
    logic signed [24:0] r_base, r_thr, r_d1, r_d2, r_hp, r_rect, r_x;
    logic signed [24:0] n_base, n_thr;
    logic [15:0] r_idx;
    logic [19:0] r_last, r_now;
    logic [11:0] r_hist [ehr_pkg::HistDepth];
    logic [2:0]  r_fill, r_slot, r_k;
    logic [8:0]  r_rate;
    logic [2:0]  r_run;
    logic        r_beat, r_need, r_alert;
    logic        r_fe;
    logic [11:0] r_intv;
    logic [14:0] r_sum;
    // Restoring division state.
    logic [15:0] r_quo;
    logic [14:0] r_rem;
    logic [11:0] r_mean;
    logic [4:0]  r_dcnt;
    logic        r_mean_busy;

    logic signed [24:0] x_w, d_base, sm_sum, sm_q, sm_abs, d_thr, thr3, rect2;
    logic [19:0] now_w, rr_w;
    logic        refr, hit, ok;
    logic [15:0] div_rem_sh;
    logic [15:0] quo_bit_rem;

    function automatic logic signed [24:0] shr(input logic signed [24:0] v,
                                               input logic [3:0] k);
        shr = v >>> k;
    endfunction

    assign x_w    = $signed({3'd0, i_sample, 10'd0});
    assign d_base = r_x - r_base;
    assign n_base = r_base + shr(d_base, i_cfg.baseline_shift);
    assign sm_sum = r_hp + r_d1 + r_d2;
    // Magnitude of the sum divided by three, rounded toward zero; the sign is dropped, so the result is rectified.
    logic [24:0] sm_mag, sm_div;
    logic [50:0] sm_prod;
    assign sm_mag  = sm_sum[24] ? 25'(-sm_sum) : 25'(sm_sum);
    assign sm_prod = 51'(sm_mag) * 51'd11184811;
    assign sm_div  = 25'(sm_prod >> 25);
    assign sm_q    = $signed(sm_div);
    assign sm_abs  = sm_q;
    assign d_thr   = r_rect - r_thr;
    assign n_thr   = r_thr + shr(d_thr, i_cfg.threshold_shift);
    assign thr3    = r_thr + (r_thr <<< 1);
    assign rect2   = r_rect <<< 1;
    // now = idx*8 ms at 125 Hz.
    assign now_w   = {1'b0, r_idx, 3'd0};
    assign rr_w    = r_now - r_last;
    assign refr    = (r_last != 20'd0) && (rr_w < 20'(i_cfg.refractory_ms));
    assign hit     = !refr && (rect2 > thr3);
    assign ok      = (r_last != 20'd0) && (rr_w >= 20'(i_cfg.min_interval_ms))
                     && (rr_w <= 20'(i_cfg.max_interval_ms));
    assign div_rem_sh  = {r_rem, r_quo[15]};
    assign quo_bit_rem = div_rem_sh - {4'd0, r_mean};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.leads_off) begin
            r_base <= '0; r_thr <= '0; r_d1 <= '0; r_d2 <= '0;
            r_idx <= '0; r_last <= '0; r_fill <= '0; r_slot <= '0;
            r_rate <= '0; r_run <= '0; r_beat <= 1'b0; r_need <= 1'b0;
            r_alert <= 1'b0; r_intv <= '0;
        end else begin
            if (i_cmd.load) begin
                r_x <= x_w;
                r_fe <= i_frame_end;
                r_beat <= 1'b0; r_need <= 1'b0; r_alert <= 1'b0; r_intv <= '0;
                if (i_frame_start) begin
                    r_base <= '0; r_thr <= '0; r_d1 <= '0; r_d2 <= '0;
                    r_idx <= '0; r_last <= '0; r_fill <= '0; r_slot <= '0;
                    r_rate <= '0;
                end
            end
            if (i_cmd.filter) begin
                r_base <= n_base;
                r_hp   <= r_x - n_base;
                r_now  <= now_w;
                if (r_idx != 16'(ehr_pkg::IndexMax)) r_idx <= r_idx + 16'd1;
            end
            if (i_cmd.smooth) begin
                r_d2 <= r_d1;
                r_d1 <= r_hp;
                r_rect <= sm_abs;
            end
            if (i_cmd.detect) begin
                r_thr <= n_thr;
            end
            // Detection uses the updated threshold, so it runs afterwards, in sum_start.
            if (i_cmd.sum_start) begin
                if (hit) begin
                    r_beat <= 1'b1;
                    r_last <= r_now;
                    if (ok) begin
                        r_need <= 1'b1;
                        r_intv <= rr_w[11:0];
                        r_hist[r_slot] <= rr_w[11:0];
                        r_slot <= (r_slot == 3'(ehr_pkg::HistDepth - 1)) ? 3'd0 : r_slot + 3'd1;
                        if (r_fill < 3'(ehr_pkg::HistDepth)) r_fill <= r_fill + 3'd1;
                    end
                end
                r_sum <= '0;
                r_k   <= '0;
            end
            if (i_cmd.sum_step && r_k < r_fill) begin
                r_sum <= r_sum + 15'(r_hist[r_k]);
                r_k   <= r_k + 3'd1;
            end
            if (i_cmd.div_start) begin
                // mean = sum / fill, then 60000 / mean: both by bit-serial division.
                r_quo  <= {1'b0, r_sum};
                r_rem  <= '0;
                r_mean <= {9'd0, r_fill};
                r_dcnt <= 5'd16;
                r_mean_busy <= 1'b1;
            end
            if (i_cmd.div_step && r_dcnt != 5'd0) begin
                if (quo_bit_rem[15] == 1'b0) begin
                    r_rem <= quo_bit_rem[14:0];
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_rem <= div_rem_sh[14:0];
                    r_quo <= {r_quo[14:0], 1'b0};
                end
                r_dcnt <= r_dcnt - 5'd1;
            end else if (i_cmd.div_step && r_mean_busy) begin
                r_mean_busy <= 1'b0;
                r_mean <= r_quo[11:0];
                r_quo  <= 16'(ehr_pkg::MsPerMin);
                r_rem  <= '0;
                r_dcnt <= 5'd16;
            end else if (i_cmd.div_step) begin
                if (r_mean == 12'd0 || r_quo > 16'(ehr_pkg::RateCap)) r_rate <= 9'(ehr_pkg::RateCap);
                else r_rate <= r_quo[8:0];
            end
            if (i_cmd.frame && r_fe) begin
                if (r_rate > i_cfg.rate_alert_bpm) begin
                    if (r_run < i_cfg.alert_frames) r_run <= r_run + 3'd1;
                    r_alert <= (r_run + 3'd1 >= i_cfg.alert_frames) ||
                               (r_run >= i_cfg.alert_frames);
                end else begin
                    r_run <= '0;
                    r_alert <= (i_cfg.alert_frames == 3'd0);
                end
            end
        end
    end

    assign o_sts.need_rate = r_need;
    assign o_sts.sum_done  = (r_k >= r_fill);
    assign o_sts.div_done  = !r_mean_busy && (r_dcnt == 5'd0);
    assign o_result.beat            = r_beat;
    assign o_result.interval_ms     = r_intv;
    assign o_result.heart_rate      = r_rate;
    assign o_result.rate_alert      = r_alert;
    assign o_result.leads_off_alert = 1'b0;
endmodule

/* hw/rtl/ehr_controller.sv */
// Controller state machine sequencing one item through the datapath.
module ehr_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_kind,
    input  logic             i_out_ready,
    input  ehr_pkg::t_sts    i_sts,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output logic             o_leads_off,
    output ehr_pkg::t_cmd    o_cmd
);
    ehr_pkg::t_state r_state, n_state;
    logic r_lo, n_lo;
    logic take;

    assign take = i_in_valid && (r_state == ehr_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ehr_pkg::ST_IDLE;
            r_lo    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lo    <= n_lo;
        end
    end

    // The first cycle in the sum state issues sum_start; later cycles step the ring.
    logic r_first;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_first <= 1'b0;
        else r_first <= (r_state == ehr_pkg::ST_DETECT);
    end

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        case (r_state)
            ehr_pkg::ST_IDLE: begin
                if (take) begin
                    n_lo    = i_in_kind;
                    n_state = i_in_kind ? ehr_pkg::ST_OUTPUT : ehr_pkg::ST_FILTER;
                end
            end
            ehr_pkg::ST_FILTER: n_state = ehr_pkg::ST_SMOOTH;
            ehr_pkg::ST_SMOOTH: n_state = ehr_pkg::ST_DETECT;
            ehr_pkg::ST_DETECT: n_state = ehr_pkg::ST_SUM;
            ehr_pkg::ST_SUM: begin
                if (!r_first && i_sts.sum_done) begin
                    n_state = i_sts.need_rate ? ehr_pkg::ST_DIVIDE : ehr_pkg::ST_FRAME;
                end
            end
            ehr_pkg::ST_DIVIDE: begin
                if (i_sts.div_done) n_state = ehr_pkg::ST_FRAME;
            end
            ehr_pkg::ST_FRAME: n_state = ehr_pkg::ST_OUTPUT;
            ehr_pkg::ST_OUTPUT: begin
                if (i_out_ready) n_state = ehr_pkg::ST_IDLE;
            end
            default: n_state = ehr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_leads_off = r_lo;
        case (r_state)
            ehr_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load    = take && !i_in_kind;
                o_cmd.leads_off = take && i_in_kind;
            end
            ehr_pkg::ST_FILTER: o_cmd.filter = 1'b1;
            ehr_pkg::ST_SMOOTH: o_cmd.smooth = 1'b1;
            ehr_pkg::ST_DETECT: o_cmd.detect = 1'b1;
            ehr_pkg::ST_SUM: begin
                o_cmd.sum_start = r_first;
                o_cmd.sum_step  = !r_first;
                o_cmd.div_start = !r_first && i_sts.sum_done && i_sts.need_rate;
            end
            ehr_pkg::ST_DIVIDE: o_cmd.div_step = 1'b1;
            ehr_pkg::ST_FRAME:  o_cmd.frame = 1'b1;
            ehr_pkg::ST_OUTPUT: o_out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule

/* hw/rtl/ecg_heart_rate_detector.sv */
// Top level of the ECG heart rate detector.
// Input channel carries one transfer per ECG sample or leads-off event; the
// output channel returns exactly one result transfer per input transfer.
// An item is processed alone: the input is ready only while the block is idle.
// A leads-off event presents its result in the cycle after its input transfer.
// A sample passes through the filter, smooth and detect states, then the sum
// state, which steps through each filled interval ring entry (up to 5), then
// bit-serial division when a new interval is accepted (mean, then 60000 / mean),
// then the frame state, before its result is presented. After each result
// transfer the block returns to its idle state before it takes the next item.
// The result is held on the output until it is transferred; a stalled receiver
// simply holds the block in its output state and the input stays not ready.
// Reset (synchronous, active low) restores the register defaults and clears the
// filter, threshold, beat timing, ring count, rate and alert state, not the sum and
// divider state. APB-style port, pready always high; registers at byte address 4*index.
module ecg_heart_rate_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ehr_in_if.sink      i_in,
    ehr_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    ehr_pkg::t_cfg    r_cfg;
    ehr_pkg::t_cmd    cmd;
    ehr_pkg::t_sts    sts;
    ehr_pkg::t_result res;
    logic             leads_off;
    logic [2:0]       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.baseline_shift  <= 4'd7;
            r_cfg.threshold_shift <= 4'd4;
            r_cfg.refractory_ms   <= 11'd250;
            r_cfg.min_interval_ms <= 12'd300;
            r_cfg.max_interval_ms <= 12'd1500;
            r_cfg.rate_alert_bpm  <= 9'd105;
            r_cfg.alert_frames    <= 3'd5;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                ehr_pkg::RegBaseShift:  r_cfg.baseline_shift  <= pwdata[3:0];
                ehr_pkg::RegThrShift:   r_cfg.threshold_shift <= pwdata[3:0];
                ehr_pkg::RegRefractory: r_cfg.refractory_ms   <= pwdata[10:0];
                ehr_pkg::RegMinIntv:    r_cfg.min_interval_ms <= pwdata[11:0];
                ehr_pkg::RegMaxIntv:    r_cfg.max_interval_ms <= pwdata[11:0];
                ehr_pkg::RegAlertBpm:   r_cfg.rate_alert_bpm  <= pwdata[8:0];
                ehr_pkg::RegAlertFrm:   r_cfg.alert_frames    <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            ehr_pkg::RegBaseShift:  prdata = {28'd0, r_cfg.baseline_shift};
            ehr_pkg::RegThrShift:   prdata = {28'd0, r_cfg.threshold_shift};
            ehr_pkg::RegRefractory: prdata = {21'd0, r_cfg.refractory_ms};
            ehr_pkg::RegMinIntv:    prdata = {20'd0, r_cfg.min_interval_ms};
            ehr_pkg::RegMaxIntv:    prdata = {20'd0, r_cfg.max_interval_ms};
            ehr_pkg::RegAlertBpm:   prdata = {23'd0, r_cfg.rate_alert_bpm};
            ehr_pkg::RegAlertFrm:   prdata = {29'd0, r_cfg.alert_frames};
            default:                prdata = 32'd0;
        endcase
    end

    ehr_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_kind   (i_in.kind),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_leads_off (leads_off),
        .o_cmd       (cmd)
    );

    ehr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (cmd),
        .i_sample      (i_in.sample),
        .i_frame_start (i_in.frame_start),
        .i_frame_end   (i_in.frame_end),
        .o_sts         (sts),
        .o_result      (res)
    );

    assign o_out.beat            = leads_off ? 1'b0 : res.beat;
    assign o_out.interval_ms     = leads_off ? 12'd0 : res.interval_ms;
    assign o_out.heart_rate      = leads_off ? 9'd0 : res.heart_rate;
    assign o_out.rate_alert      = leads_off ? 1'b0 : res.rate_alert;
    assign o_out.leads_off_alert = leads_off;
endmodule
